// ===== hw/rtl/nfa_pkg.sv =====
// Shared types and constants of the NFA word acceptor.
package nfa_pkg;

    // Fixed field widths of the item and configuration channels.
    localparam int SYMBOL_W   = 8;
    localparam int STATE_W    = 4;
    localparam int FINAL_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Item function codes.
    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_WORD = 1'b1
    } t_func;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STATE = 1'b0,
        CFG_FINAL_MASK  = 1'b1
    } t_cfg_reg;

    // Classified item as it travels from front to back.
    typedef struct packed {
        t_func               func;
        logic [SYMBOL_W-1:0] sym;
        logic [STATE_W-1:0]  from_state;
        logic [STATE_W-1:0]  to_state;
        logic                last;
        logic                load_ok;
    } t_cmd;

    // Queue to back part.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Front part to queue.
    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_push;

    // Configuration values seen by the back part.
    typedef struct packed {
        logic [STATE_W-1:0] start_state;
        logic [FINAL_W-1:0] final_mask;
    } t_cfg;

endpackage

// ===== hw/rtl/nfa_if.sv =====
// Handshake channel interfaces of the NFA word acceptor.
interface nfa_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [nfa_pkg::SYMBOL_W-1:0] symbol;
    logic [nfa_pkg::STATE_W-1:0]  from_state;
    logic [nfa_pkg::STATE_W-1:0]  to_state;
    logic                         last;

    modport source (output valid, func, symbol, from_state, to_state, last, input ready);
    modport sink   (input valid, func, symbol, from_state, to_state, last, output ready);
endinterface

interface nfa_out_if;
    logic valid;
    logic ready;
    logic accepted;
    logic word_end;

    modport source (output valid, accepted, word_end, input ready);
    modport sink   (input valid, accepted, word_end, output ready);
endinterface

interface nfa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [nfa_pkg::CFG_IDX_W-1:0]  index;
    logic [nfa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/nfa_word_acceptor.sv =====
// A result passes the queue, the read stage register and the result register after
// its item is accepted. Throughput: one item per cycle while the result port takes
// results, set by the loop that folds the registered table row of a symbol into the
// active state set. Reset: the transition table reads as empty at once through one
// flag per symbol row; no clearing pass, items are taken from the first cycle on.
module nfa_word_acceptor #(
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nfa_in_if.sink      i_item,
    nfa_cfg_if.sink     i_cfg,
    nfa_out_if.source   o_res
);

    logic [nfa_pkg::STATE_W-1:0] r_start_state;
    logic [nfa_pkg::FINAL_W-1:0] r_final_mask;
    nfa_pkg::t_cfg               w_cfg;
    nfa_pkg::t_q_push            w_q_push;
    nfa_pkg::t_q_head            w_q_head;
    logic                        w_q_full;
    logic                        w_pop;

    // Configuration registers; the port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_final_mask  <= '0;
        end else if (i_cfg.valid) begin
            unique case (nfa_pkg::t_cfg_reg'(i_cfg.index))
                nfa_pkg::CFG_START_STATE: r_start_state <= i_cfg.data[nfa_pkg::STATE_W-1:0];
                nfa_pkg::CFG_FINAL_MASK:  r_final_mask  <= i_cfg.data[nfa_pkg::FINAL_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_cfg.start_state = r_start_state;
    assign w_cfg.final_mask  = r_final_mask;

    nfa_front #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_front (
        .i_item   (i_item),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push)
    );

    nfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_head  (w_q_head)
    );

    nfa_back #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_head  (w_q_head),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

// ===== hw/rtl/nfa_front.sv =====
// Front part: takes items and classifies them for the back part.
module nfa_front #(
    parameter int NUM_STATES,
    parameter int SYMBOL_BITS
) (
    nfa_in_if.sink            i_item,
    input  logic              i_q_full,
    output nfa_pkg::t_q_push  o_q_push
);

    nfa_pkg::t_cmd w_cmd;

    // Mask the symbol to the table width and check that a load names real states.
    always_comb begin
        w_cmd            = '0;
        w_cmd.func       = nfa_pkg::t_func'(i_item.func);
        w_cmd.sym        = nfa_pkg::SYMBOL_W'(i_item.symbol[SYMBOL_BITS-1:0]);
        w_cmd.from_state = i_item.from_state;
        w_cmd.to_state   = i_item.to_state;
        w_cmd.last       = i_item.last;
        w_cmd.load_ok    = (int'(i_item.from_state) < NUM_STATES) &&
                           (int'(i_item.to_state) < NUM_STATES);
    end

    // An item is taken whenever the queue has room.
    assign i_item.ready  = !i_q_full;
    assign o_q_push.push = i_item.valid && !i_q_full;
    assign o_q_push.cmd  = w_cmd;

endmodule

// ===== hw/rtl/nfa_queue.sv =====
// Short queue between the front and back parts.
module nfa_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nfa_pkg::t_q_push  i_push,
    input  logic              i_pop,
    output logic              o_full,
    output nfa_pkg::t_q_head  o_head
);

    localparam int PTR_W = $clog2(nfa_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(nfa_pkg::QUEUE_DEPTH + 1);

    nfa_pkg::t_cmd    r_entry [nfa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_pop;

    assign o_full       = (r_count == CNT_W'(nfa_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_entry[r_rd_ptr];
    assign w_do_pop     = i_pop && (r_count != '0);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_entry[r_wr_ptr] <= i_push.cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(nfa_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(nfa_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push.push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/nfa_back.sv =====
// Back part: transition table, active state set and result register.
module nfa_back #(
    parameter int NUM_STATES,
    parameter int SYMBOL_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nfa_pkg::t_cfg     i_cfg,
    input  nfa_pkg::t_q_head  i_head,
    output logic              o_pop,
    nfa_out_if.source         o_res
);

    localparam int ROW_W = NUM_STATES * NUM_STATES;
    localparam int DEPTH = 2 ** SYMBOL_BITS;
    localparam int IDX_W = $clog2(ROW_W);
    localparam int FIN_W = (NUM_STATES < nfa_pkg::FINAL_W) ? NUM_STATES : nfa_pkg::FINAL_W;

    // Table rows, one per symbol; bit s*NUM_STATES+t marks s --symbol--> t.
    logic [ROW_W-1:0]       r_mem [DEPTH];
    logic [DEPTH-1:0]       r_row_used;

    logic                   r_s1_vld;
    nfa_pkg::t_cmd          r_s1;
    logic [ROW_W-1:0]       r_row;
    logic                   r_row_ok;

    logic [NUM_STATES-1:0]  r_active;
    logic [NUM_STATES-1:0]  n_active;
    logic                   r_word_begin;

    logic                   r_out_vld;
    logic                   r_out_acc;
    logic                   r_out_end;

    logic                   w_out_free;
    logic                   w_s1_adv;
    logic [SYMBOL_BITS-1:0] w_addr;
    logic                   w_load;
    logic [IDX_W-1:0]       w_bit_idx;
    logic [ROW_W-1:0]       w_row_eff;
    logic [NUM_STATES-1:0]  w_start_set;
    logic [NUM_STATES-1:0]  w_cur;
    logic                   w_acc;

    // Pipeline flow: the read stage advances when the result register frees up.
    assign w_out_free = !r_out_vld || o_res.ready;
    assign w_s1_adv   = r_s1_vld && w_out_free;
    assign o_pop      = i_head.valid && (!r_s1_vld || w_s1_adv);

    assign w_addr    = i_head.cmd.sym[SYMBOL_BITS-1:0];
    assign w_load    = o_pop && (i_head.cmd.func == nfa_pkg::FUNC_LOAD) && i_head.cmd.load_ok;
    assign w_bit_idx = IDX_W'(int'(i_head.cmd.from_state) * NUM_STATES +
                              int'(i_head.cmd.to_state));

    // Table memory: a first load into a row overwrites it, later loads set one bit.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_row_used[w_addr]) begin
                r_mem[w_addr][w_bit_idx] <= 1'b1;
            end else begin
                r_mem[w_addr] <= ROW_W'(1) << w_bit_idx;
            end
        end
        if (o_pop) begin
            r_row <= r_mem[w_addr];
        end
    end

    // Row flags: a row never loaded since reset reads as empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_used <= '0;
            r_row_ok   <= 1'b0;
        end else begin
            if (w_load) begin
                r_row_used[w_addr] <= 1'b1;
            end
            if (o_pop) begin
                r_row_ok <= r_row_used[w_addr];
            end
        end
    end

    // Read stage holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_pop) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_head.cmd;
        end
    end

    // Start set holds only the start state, if it exists.
    always_comb begin
        for (int i = 0; i < NUM_STATES; i++) begin
            w_start_set[i] = (int'(i_cfg.start_state) == i);
        end
    end

    // Union of the targets of all active states under this symbol.
    assign w_row_eff = r_row_ok ? r_row : '0;
    assign w_cur     = r_word_begin ? w_start_set : r_active;

    always_comb begin
        n_active = '0;
        for (int s = 0; s < NUM_STATES; s++) begin
            if (w_cur[s]) begin
                n_active = n_active | w_row_eff[s*NUM_STATES +: NUM_STATES];
            end
        end
    end

    assign w_acc = |(n_active[FIN_W-1:0] & i_cfg.final_mask[FIN_W-1:0]);

    // Active set and word framing update on each word symbol.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_word_begin <= 1'b1;
        end else if (w_s1_adv && (r_s1.func == nfa_pkg::FUNC_WORD)) begin
            if (r_s1.last) begin
                r_active     <= '0;
                r_word_begin <= 1'b1;
            end else begin
                r_active     <= n_active;
                r_word_begin <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_end <= (r_s1.func == nfa_pkg::FUNC_WORD) && r_s1.last;
            r_out_acc <= (r_s1.func == nfa_pkg::FUNC_WORD) && r_s1.last && w_acc;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.accepted = r_out_acc;
    assign o_res.word_end = r_out_end;

endmodule
